// ===== hw/rtl/tdmr_pkg.sv =====
// tdmr_pkg: types, constants and the 3x5 digit font for the two-digit matrix renderer.
// Used by every file of the block; depends on nothing.
`default_nettype none

package tdmr_pkg;

    localparam int NUMBER_W   = 8;
    localparam int ADDR_W     = 4;
    localparam int PATTERN_W  = 8;
    localparam int DIGIT_W    = 4;
    localparam int STEP_W     = 4;    // sixteen row writes per item
    localparam int GLYPH_W    = 3;
    localparam int GLYPH_ROWS = 5;
    localparam int MATRIX_ROWS = 8;

    localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

    // reciprocal for the split by ten: (n * 205) >> 11 is exact for n below 1024
    localparam logic [7:0] RECIP_TEN       = 8'd205;
    localparam int         RECIP_TEN_SHIFT = 11;

    // one word per digit, font row 0 in the top three bits
    localparam logic [GLYPH_W*GLYPH_ROWS-1:0] FONT_ROWS [10] = '{
        15'b111_101_101_101_111,
        15'b010_110_010_010_111,
        15'b111_001_111_100_111,
        15'b111_001_111_001_111,
        15'b101_101_111_001_001,
        15'b111_100_111_001_111,
        15'b111_100_111_101_111,
        15'b111_101_101_001_001,
        15'b111_101_111_101_111,
        15'b111_101_111_001_111
    };

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
        logic [STEP_W-1:0]  step;
    } row_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    row_address;
        logic [PATTERN_W-1:0] row_pattern;
        logic                 last_of_run;
    } row_item_t;

    function automatic logic [GLYPH_W-1:0] glyph_row(input logic [DIGIT_W-1:0] digit,
                                                     input logic [2:0] row);
        logic [GLYPH_W*GLYPH_ROWS-1:0] word;
        logic [GLYPH_W-1:0]            bits;
        word = (digit > 4'd9) ? '0 : FONT_ROWS[digit];
        case (row)
            3'd0:    bits = word[14:12];
            3'd1:    bits = word[11:9];
            3'd2:    bits = word[8:6];
            3'd3:    bits = word[5:3];
            3'd4:    bits = word[2:0];
            default: bits = '0;       // blank rows below the glyph
        endcase
        return bits;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdmr_num_if.sv =====
// tdmr_num_if: valid/ready channel that carries one number item into the renderer.
// Depends on tdmr_pkg.
`default_nettype none

interface tdmr_num_if
    import tdmr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [NUMBER_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tdmr_row_if.sv =====
// tdmr_row_if: valid/ready channel that carries one row-register write item.
// Depends on tdmr_pkg.
`default_nettype none

interface tdmr_row_if
    import tdmr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    row_address;
    logic [PATTERN_W-1:0] row_pattern;
    logic                 last_of_run;

    modport source (output valid, output row_address, output row_pattern,
                    output last_of_run, input ready);
    modport sink   (input valid, input row_address, input row_pattern,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tdmr_row_gen.sv =====
// tdmr_row_gen: builds one row write from the two digits and the step of the run.
// Steps 0..7 clear the matrix, steps 8..15 draw; depends on tdmr_pkg.
`default_nettype none

module tdmr_row_gen
    import tdmr_pkg::*;
(
    input  row_req_t  req,
    output row_item_t item
);

    logic [2:0]         row;
    logic               draw;
    logic [GLYPH_W-1:0] tens_bits;
    logic [GLYPH_W-1:0] ones_bits;

    assign row       = req.step[2:0];
    assign draw      = req.step[3];
    assign tens_bits = glyph_row(req.tens, row);
    assign ones_bits = glyph_row(req.ones, row);

    always_comb
    begin
        item.row_address = {1'b0, row} + 4'd1;
        // tens glyph in bits 6..4, ones glyph in bits 2..0
        item.row_pattern = draw ? {1'b0, tens_bits, 1'b0, ones_bits} : '0;
        item.last_of_run = (req.step == STEP_LAST);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/two_digit_matrix_renderer.sv =====
// two_digit_matrix_renderer: turns a byte into sixteen row writes that show its last two
// decimal digits on an 8x8 matrix. Depends on tdmr_pkg, tdmr_num_if, tdmr_row_if, tdmr_row_gen.
//
//   channel   dir   payload                                   handshake
//   num       in    number[7:0]                               valid/ready
//   rows      out   row_address[3:0] row_pattern[7:0] last    valid/ready
//
// The step counter emits one row write per cycle into the output register unless rows stalls.
// The next item is taken in the cycle the last row of the current one loads, so a steady
// stream keeps the output busy every cycle; an accepted item is held in the digit registers
// ahead of the output register. Reset clears the valid flags and the step counter. A stall
// on rows holds the output register and the counter; num is held off while an item is in work.
`default_nettype none

module two_digit_matrix_renderer
    import tdmr_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    tdmr_num_if.sink    num,
    tdmr_row_if.source  rows
);

    // digit split of the incoming item
    logic [15:0]        prod;
    logic [4:0]         quot;
    logic [7:0]         tenq;
    logic [DIGIT_W-1:0] tens_in;
    logic [DIGIT_W-1:0] ones_in;

    assign prod = {8'd0, num.number} * {8'd0, RECIP_TEN};
    assign quot = prod[RECIP_TEN_SHIFT +: 5];
    assign tenq = {quot, 3'd0} + {2'd0, quot, 1'b0};
    assign ones_in = 4'(num.number - tenq);

    always_comb
    begin
        // drop the hundreds
        if (quot >= 5'd20)
            tens_in = 4'(quot - 5'd20);
        else if (quot >= 5'd10)
            tens_in = 4'(quot - 5'd10);
        else
            tens_in = quot[3:0];
    end

    logic               a_valid_reg, a_valid_next;
    logic [DIGIT_W-1:0] tens_reg, ones_reg;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    row_item_t          item_reg;
    row_item_t          item_next;
    row_req_t           req;
    logic               load;
    logic               take;

    assign load      = a_valid_reg && (!out_valid_reg || rows.ready);
    assign num.ready = !a_valid_reg || (load && step_reg == STEP_LAST);
    assign take      = num.valid && num.ready;

    assign req.tens = tens_reg;
    assign req.ones = ones_reg;
    assign req.step = step_reg;

    tdmr_row_gen u_row_gen (
        .req  (req),
        .item (item_next)
    );

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (take)
            a_valid_next = 1'b1;
        else if (load && step_reg == STEP_LAST)
            a_valid_next = 1'b0;

        step_next = load ? step_reg + 4'd1 : step_reg;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (rows.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tens_reg <= tens_in;
            ones_reg <= ones_in;
        end
        if (load)
            item_reg <= item_next;
    end

    assign rows.valid       = out_valid_reg;
    assign rows.row_address = item_reg.row_address;
    assign rows.row_pattern = item_reg.row_pattern;
    assign rows.last_of_run = item_reg.last_of_run;

    // a new item may only land when the held one is done or absent
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        take && a_valid_reg |-> load && step_reg == STEP_LAST)
        else $error("item accepted over one still in work");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        load && step_reg != STEP_LAST |=> a_valid_reg)
        else $error("item dropped before its last row");

    a_step_adv: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> step_reg == 4'($past(step_reg) + 4'd1))
        else $error("step counter did not advance on load");

    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(step_reg))
        else $error("step counter moved without a load");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        load && step_reg == STEP_LAST |=> rows.valid && rows.last_of_run)
        else $error("last row of a run not flagged");

endmodule

`default_nettype wire
